/* design/ptls_pkg.sv */
// ----------------------------------------------------------------------------
// ptls_pkg: shared types and constants of the process table scheduler
// Record layout, operation and outcome codes, controller/datapath bundles.
// ----------------------------------------------------------------------------
package ptls_pkg;

	localparam int SLOTS   = 64;
	localparam int SLOT_W  = 6;
	localparam int PTR_W   = SLOT_W + 1;
	localparam int ID_W    = 31;
	localparam int CHAN_W  = 15;
	localparam int SCHAN_W = 16;
	localparam int CODE_W  = 32;
	localparam int FUNC_W  = 3;
	localparam int OC_W    = 3;
	localparam int ST_W    = 3;

	localparam logic [PTR_W-1:0] NO_SLOT = PTR_W'(SLOTS);
	localparam logic [ID_W-1:0]  ID_MAX  = {ID_W{1'b1}};

	// operation codes
	localparam logic [FUNC_W-1:0] F_CREATE = 3'd0;
	localparam logic [FUNC_W-1:0] F_SCHED  = 3'd1;
	localparam logic [FUNC_W-1:0] F_YIELD  = 3'd2;
	localparam logic [FUNC_W-1:0] F_SLEEP  = 3'd3;
	localparam logic [FUNC_W-1:0] F_WAKE   = 3'd4;
	localparam logic [FUNC_W-1:0] F_KILL   = 3'd5;
	localparam logic [FUNC_W-1:0] F_EXIT   = 3'd6;
	localparam logic [FUNC_W-1:0] F_WAIT   = 3'd7;

	// outcome codes
	localparam logic [OC_W-1:0] OC_OK      = 3'd0;
	localparam logic [OC_W-1:0] OC_FULL    = 3'd1;
	localparam logic [OC_W-1:0] OC_NO_ID   = 3'd2;
	localparam logic [OC_W-1:0] OC_NO_KIDS = 3'd3;
	localparam logic [OC_W-1:0] OC_BLOCKED = 3'd4;
	localparam logic [OC_W-1:0] OC_NONE_RN = 3'd5;
	localparam logic [OC_W-1:0] OC_INIT_EX = 3'd6;
	localparam logic [OC_W-1:0] OC_NO_CUR  = 3'd7;

	// slot lifecycle states
	localparam logic [ST_W-1:0] ST_UNUSED   = 3'd0;
	localparam logic [ST_W-1:0] ST_SLEEPING = 3'd2;
	localparam logic [ST_W-1:0] ST_RUNNABLE = 3'd3;
	localparam logic [ST_W-1:0] ST_RUNNING  = 3'd4;
	localparam logic [ST_W-1:0] ST_ZOMBIE   = 3'd5;

	// evaluation phases driven by the controller
	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_PRE  = 2'd1;
	localparam logic [1:0] EV_SCAN = 2'd2;
	localparam logic [1:0] EV_POST = 2'd3;

	typedef struct packed {
		logic [ST_W-1:0]    state;
		logic [ID_W-1:0]    id;
		logic [PTR_W-1:0]   parent;
		logic [SCHAN_W-1:0] chan;
		logic               killed;
		logic [CODE_W-1:0]  code;
	} rec_t;

	localparam rec_t REC_RESET = '{
		state: ST_UNUSED, id: '0, parent: NO_SLOT, chan: '0, killed: 1'b0, code: '0
	};

	typedef struct packed {
		logic              load;
		logic              decide;
		logic              finish;
		logic              rd_en;
		logic [SLOT_W-1:0] rd_addr;
		logic [1:0]        ev;
		logic [SLOT_W-1:0] ev_slot;
	} cmd_t;

	typedef struct packed {
		logic              early;
		logic              pre;
		logic              scan;
		logic              post;
		logic              hit;
		logic              post_after;
		logic [SLOT_W-1:0] scan_base;
		logic [SLOT_W-1:0] pre_addr;
		logic [SLOT_W-1:0] post_addr;
	} stat_t;

	// channel a slot sleeps on while waiting for a child
	function automatic logic [SCHAN_W-1:0] wait_chan(input logic [SLOT_W-1:0] s);
		wait_chan = {1'b1, {(SCHAN_W-1-SLOT_W){1'b0}}, s};
	endfunction

endpackage

/* design/process_table_lifecycle_scheduler.sv */
// ----------------------------------------------------------------------------
// process_table_lifecycle_scheduler: hardware process table
// Round-robin scheduler with create, schedule, yield, sleep, wakeup, kill,
// exit and wait over a 64-slot table.
//
//  channel   handshake              word contents
//  -------   --------------------   ----------------------------------------
//  command   start & !busy          func, target_id, channel, exit_code
//  result    done (one cycle)       outcome, result_id, result_slot,
//                                   reaped_status
//
// An operation may sweep the table, reading one slot per cycle from the
// single-read-port table memory, and some ops read-modify-write the caller
// or init slot.
// busy is high from acceptance through the done cycle; one word at a time.
// After reset the table is empty; no clearing pass, valid bits cover it.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module process_table_lifecycle_scheduler
	import ptls_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [FUNC_W-1:0]        func,
	input  logic [ID_W-1:0]          target_id,
	input  logic [CHAN_W-1:0]        channel,
	input  logic signed [CODE_W-1:0] exit_code,
	output logic                     done,
	output logic [OC_W-1:0]          outcome,
	output logic [ID_W-1:0]          result_id,
	output logic [SLOT_W-1:0]        result_slot,
	output logic signed [CODE_W-1:0] reaped_status
);

	cmd_t  cmd;
	stat_t st;

	// sequencer
	ptls_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// table and registers
	ptls_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.func          (func),
		.target_id     (target_id),
		.channel       (channel),
		.exit_code     (exit_code),
		.outcome       (outcome),
		.result_id     (result_id),
		.result_slot   (result_slot),
		.reaped_status (reaped_status)
	);

endmodule

/* design/ptls_ram.sv */
// ----------------------------------------------------------------------------
// ptls_ram: slot record memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ptls_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* design/ptls_dp.sv */
// ----------------------------------------------------------------------------
// ptls_dp: scheduler datapath
// Holds the slot table, valid bits, scheduler registers and result word, and
// applies each operation to the slot record the controller puts in view.
// ----------------------------------------------------------------------------
module ptls_dp
	import ptls_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	output stat_t                    st,
	input  logic [FUNC_W-1:0]        func,
	input  logic [ID_W-1:0]          target_id,
	input  logic [CHAN_W-1:0]        channel,
	input  logic signed [CODE_W-1:0] exit_code,
	output logic [OC_W-1:0]          outcome,
	output logic [ID_W-1:0]          result_id,
	output logic [SLOT_W-1:0]        result_slot,
	output logic signed [CODE_W-1:0] reaped_status
);

	logic [SLOTS-1:0]  valid_q;
	logic [ID_W-1:0]   next_id_q;
	logic [PTR_W-1:0]  cur_q, init_q, par_q;
	logic [SLOT_W-1:0] sptr_q;
	logic              kids_q, reaped_q, clr_cur_q;

	logic [FUNC_W-1:0] func_q;
	logic [ID_W-1:0]   target_q;
	logic [CHAN_W-1:0] chan_q;
	logic [CODE_W-1:0] code_q;

	logic [OC_W-1:0]   oc_q;
	logic [ID_W-1:0]   rid_q;
	logic [SLOT_W-1:0] rslot_q;
	logic [CODE_W-1:0] rstat_q;

	logic [$bits(rec_t)-1:0] rd_raw;
	rec_t              rec, wr_rec;
	logic [SLOT_W-1:0] slot_e;
	logic              cur_none, init_none, wr_en, hit, vset, vclr, kid;
	logic              res_we, cur_we, nid_we, init_we, clr_set, par_we;
	logic [OC_W-1:0]   res_oc, dflt_oc;
	logic [ID_W-1:0]   res_id;
	logic [SLOT_W-1:0] res_slot;
	logic [CODE_W-1:0] res_st;
	logic              needs_cur;
	logic [SLOT_W-1:0] pre_addr, post_addr, scan_base;
	logic              early, pre_go, scan_go, post_go, post_after;

	assign cur_none  = (cur_q == NO_SLOT);
	assign init_none = (init_q == NO_SLOT);

	// table memory
	ptls_ram #(.DEPTH(SLOTS), .WIDTH($bits(rec_t))) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (slot_e),
		.wr_data (wr_rec),
		.rd_en   (cmd.rd_en),
		.rd_addr (cmd.rd_addr),
		.rd_data (rd_raw)
	);

	// pick the slot under evaluation; an unused slot reads as its reset record
	always_comb begin
		pre_addr  = cur_q[SLOT_W-1:0];
		post_addr = (func_q == F_EXIT) ? init_q[SLOT_W-1:0] : cur_q[SLOT_W-1:0];
		scan_base = (func_q == F_SCHED) ? sptr_q : '0;
		unique case (cmd.ev)
			EV_SCAN: slot_e = cmd.ev_slot;
			EV_PRE:  slot_e = pre_addr;
			EV_POST: slot_e = post_addr;
			EV_NONE: slot_e = cmd.ev_slot;
		endcase
		rec = valid_q[slot_e] ? rec_t'(rd_raw) : REC_RESET;
	end

	// plan the operation from the latched word
	always_comb begin
		needs_cur = (func_q == F_YIELD) || (func_q == F_SLEEP) ||
			(func_q == F_EXIT) || (func_q == F_WAIT);
		early   = 1'b0;
		dflt_oc = OC_OK;
		if (needs_cur && cur_none) begin
			early   = 1'b1;
			dflt_oc = OC_NO_CUR;
		end else if (func_q == F_CREATE && !init_none && cur_none) begin
			early   = 1'b1;
			dflt_oc = OC_NO_CUR;
		end else if (func_q == F_EXIT && cur_q == init_q) begin
			early   = 1'b1;
			dflt_oc = OC_INIT_EX;
		end else begin
			case (func_q)
				F_CREATE: dflt_oc = OC_FULL;
				F_SCHED:  dflt_oc = cur_none ? OC_NONE_RN : OC_OK;
				F_KILL:   dflt_oc = OC_NO_ID;
				F_WAIT:   dflt_oc = OC_NO_KIDS;
				default:  dflt_oc = OC_OK;
			endcase
		end
		pre_go  = (func_q == F_EXIT);
		scan_go = (func_q == F_CREATE) || (func_q == F_WAKE) || (func_q == F_KILL) ||
			(func_q == F_EXIT) || (func_q == F_WAIT) || (func_q == F_SCHED && cur_none);
		post_go = (func_q == F_YIELD) || (func_q == F_SLEEP) ||
			(func_q == F_SCHED && !cur_none);
		post_after = kids_q && ((func_q == F_EXIT) || (func_q == F_WAIT && !reaped_q));
	end

	// apply the operation to the record in view
	always_comb begin
		wr_en    = 1'b0;
		wr_rec   = rec;
		hit      = 1'b0;
		vset     = 1'b0;
		vclr     = 1'b0;
		kid      = 1'b0;
		res_we   = 1'b0;
		res_oc   = OC_OK;
		res_id   = '0;
		res_slot = '0;
		res_st   = '0;
		cur_we   = 1'b0;
		nid_we   = 1'b0;
		init_we  = 1'b0;
		clr_set  = 1'b0;
		par_we   = 1'b0;
		unique case (cmd.ev)
			EV_NONE: ;
			EV_PRE: par_we = 1'b1;
			EV_SCAN: begin
				case (func_q)
					F_CREATE: begin
						if (!valid_q[slot_e]) begin
							hit      = 1'b1;
							wr_en    = 1'b1;
							vset     = 1'b1;
							wr_rec   = '{state: ST_RUNNABLE, id: next_id_q,
								parent: init_none ? NO_SLOT : cur_q,
								chan: '0, killed: 1'b0, code: '0};
							nid_we   = 1'b1;
							init_we  = init_none;
							res_we   = 1'b1;
							res_id   = next_id_q;
							res_slot = slot_e;
						end
					end
					F_SCHED: begin
						if (rec.state == ST_RUNNABLE) begin
							hit          = 1'b1;
							wr_en        = 1'b1;
							wr_rec.state = ST_RUNNING;
							cur_we       = 1'b1;
							res_we       = 1'b1;
							res_id       = rec.id;
							res_slot     = slot_e;
						end
					end
					F_WAKE: begin
						if (rec.state == ST_SLEEPING && rec.chan == {1'b0, chan_q}) begin
							wr_en        = 1'b1;
							wr_rec.state = ST_RUNNABLE;
						end
					end
					F_KILL: begin
						if (valid_q[slot_e] && rec.id == target_q) begin
							hit           = 1'b1;
							wr_en         = 1'b1;
							wr_rec.killed = 1'b1;
							if (rec.state == ST_SLEEPING) begin
								wr_rec.state = ST_RUNNABLE;
							end
							res_we = 1'b1;
						end
					end
					F_EXIT: begin
						// hand children to init
						if (rec.parent == cur_q) begin
							wr_en         = 1'b1;
							wr_rec.parent = init_q;
							kid           = 1'b1;
						end
						// wake the parent if it waits
						if ({1'b0, slot_e} == par_q && rec.state == ST_SLEEPING &&
							rec.chan == wait_chan(slot_e)) begin
							wr_en        = 1'b1;
							wr_rec.state = ST_RUNNABLE;
						end
						// turn the caller into a zombie
						if ({1'b0, slot_e} == cur_q) begin
							wr_en        = 1'b1;
							wr_rec.code  = code_q;
							wr_rec.state = ST_ZOMBIE;
							clr_set      = 1'b1;
						end
					end
					F_WAIT: begin
						if (valid_q[slot_e] && rec.parent == cur_q) begin
							kid = 1'b1;
							if (rec.state == ST_ZOMBIE) begin
								hit      = 1'b1;
								vclr     = 1'b1;
								res_we   = 1'b1;
								res_id   = rec.id;
								res_slot = slot_e;
								res_st   = rec.code;
							end
						end
					end
					default: ;
				endcase
			end
			EV_POST: begin
				case (func_q)
					F_SCHED: begin
						res_we   = 1'b1;
						res_id   = rec.id;
						res_slot = slot_e;
					end
					F_YIELD: begin
						wr_en        = 1'b1;
						wr_rec.state = ST_RUNNABLE;
						clr_set      = 1'b1;
					end
					F_SLEEP: begin
						wr_en        = 1'b1;
						wr_rec.chan  = {1'b0, chan_q};
						wr_rec.state = ST_SLEEPING;
						clr_set      = 1'b1;
					end
					F_EXIT: begin
						if (rec.state == ST_SLEEPING && rec.chan == wait_chan(slot_e)) begin
							wr_en        = 1'b1;
							wr_rec.state = ST_RUNNABLE;
						end
					end
					F_WAIT: begin
						if (!rec.killed) begin
							wr_en        = 1'b1;
							wr_rec.chan  = wait_chan(slot_e);
							wr_rec.state = ST_SLEEPING;
							clr_set      = 1'b1;
							res_we       = 1'b1;
							res_oc       = OC_BLOCKED;
						end
					end
					default: ;
				endcase
			end
		endcase
	end

	// status back to the controller
	assign st = '{early: early, pre: pre_go, scan: scan_go, post: post_go, hit: hit,
		post_after: post_after, scan_base: scan_base, pre_addr: pre_addr,
		post_addr: post_addr};

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			next_id_q <= ID_W'(1);
			cur_q     <= NO_SLOT;
			init_q    <= NO_SLOT;
			sptr_q    <= '0;
			kids_q    <= 1'b0;
			reaped_q  <= 1'b0;
			clr_cur_q <= 1'b0;
		end else begin
			if (cmd.decide) begin
				kids_q    <= 1'b0;
				reaped_q  <= 1'b0;
				clr_cur_q <= 1'b0;
			end
			if (kid) begin
				kids_q <= 1'b1;
			end
			if (vclr) begin
				reaped_q        <= 1'b1;
				valid_q[slot_e] <= 1'b0;
			end
			if (vset) begin
				valid_q[slot_e] <= 1'b1;
			end
			if (clr_set) begin
				clr_cur_q <= 1'b1;
			end
			if (nid_we) begin
				next_id_q <= (next_id_q == ID_MAX) ? ID_W'(1) : next_id_q + ID_W'(1);
			end
			if (init_we) begin
				init_q <= {1'b0, slot_e};
			end
			if (cur_we) begin
				cur_q  <= {1'b0, slot_e};
				sptr_q <= slot_e + SLOT_W'(1);
			end
			if (cmd.finish && clr_cur_q) begin
				cur_q <= NO_SLOT;
			end
		end
	end

	// operation word, parent of the caller and result word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= func;
			target_q <= target_id;
			chan_q   <= channel;
			code_q   <= unsigned'(exit_code);
		end
		if (par_we) begin
			par_q <= rec.parent;
		end
		if (cmd.decide) begin
			oc_q    <= dflt_oc;
			rid_q   <= '0;
			rslot_q <= '0;
			rstat_q <= '0;
		end else if (res_we) begin
			oc_q    <= res_oc;
			rid_q   <= res_id;
			rslot_q <= res_slot;
			rstat_q <= res_st;
		end
	end

	assign outcome       = oc_q;
	assign result_id     = rid_q;
	assign result_slot   = rslot_q;
	assign reaped_status = signed'(rstat_q);

endmodule

/* design/ptls_ctrl.sv */
// ----------------------------------------------------------------------------
// ptls_ctrl: scheduler controller
// Sequences each operation: decide, optional caller read, optional table
// sweep one slot per cycle, optional single-slot update, then result strobe.
// ----------------------------------------------------------------------------
module ptls_ctrl
	import ptls_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t st,
	output cmd_t  cmd,
	output logic  busy,
	output logic  done
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DECIDE  = 4'd1;
	localparam logic [3:0] S_PRE_RD  = 4'd2;
	localparam logic [3:0] S_PRE_EV  = 4'd3;
	localparam logic [3:0] S_SCAN    = 4'd4;
	localparam logic [3:0] S_AFTER   = 4'd5;
	localparam logic [3:0] S_POST_RD = 4'd6;
	localparam logic [3:0] S_POST_EV = 4'd7;
	localparam logic [3:0] S_DONE    = 4'd8;

	logic [3:0]        state_q, state_d;
	logic [PTR_W-1:0]  cnt_q;
	logic              ev_s1, ev_last_s1, issue, stop;
	logic [SLOT_W-1:0] ev_slot_s1;

	assign issue = (state_q == S_SCAN) && (cnt_q < PTR_W'(SLOTS));
	assign stop  = (state_q == S_SCAN) && ev_s1 && (st.hit || ev_last_s1);

	// next state and commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.ev      = EV_NONE;
		cmd.ev_slot = ev_slot_s1;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				if (st.early)     state_d = S_DONE;
				else if (st.pre)  state_d = S_PRE_RD;
				else if (st.scan) state_d = S_SCAN;
				else if (st.post) state_d = S_POST_RD;
				else              state_d = S_DONE;
			end
			S_PRE_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = st.pre_addr;
				state_d     = S_PRE_EV;
			end
			S_PRE_EV: begin
				cmd.ev  = EV_PRE;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				cmd.rd_en   = issue;
				cmd.rd_addr = st.scan_base + cnt_q[SLOT_W-1:0];
				cmd.ev      = ev_s1 ? EV_SCAN : EV_NONE;
				if (stop) begin
					state_d = S_AFTER;
				end
			end
			S_AFTER: state_d = st.post_after ? S_POST_RD : S_DONE;
			S_POST_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = st.post_addr;
				state_d     = S_POST_EV;
			end
			S_POST_EV: begin
				cmd.ev  = EV_POST;
				state_d = S_DONE;
			end
			S_DONE: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state, sweep counter and read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			ev_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			ev_s1   <= issue && !stop;
			if (state_q != S_SCAN) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + PTR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		ev_slot_s1 <= cmd.rd_addr;
		ev_last_s1 <= (cnt_q == PTR_W'(SLOTS - 1));
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	// a slot being written back is never read in the same cycle
	a_no_rmw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ev_s1 && cmd.rd_en) |-> (cmd.rd_addr != ev_slot_s1))
		else $error("sweep read collides with write-back slot");

	// the sweep never reads past the table
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= PTR_W'(SLOTS))
		else $error("sweep counter out of range");

	// one strobe per operation, then idle
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe not followed by idle");

	// evaluation only follows an issued read in the sweep
	a_ev_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		ev_s1 |-> $past(issue))
		else $error("evaluation without a read");

endmodule

/* sim/tb_process_table_lifecycle_scheduler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_process_table_lifecycle_scheduler: self-checking bench for the process table
// Drives command words in random bursts and predicts every result from a
// behavioral copy of the table kept in the bench. Directed tasks cover the
// error outcomes, init handling and a full table. A random lifecycle phase
// then alternates between filling and draining the table.
// ----------------------------------------------------------------------------
module tb_process_table_lifecycle_scheduler;
	import ptls_pkg::*;

	typedef struct {
		logic [OC_W-1:0]   oc;
		logic [ID_W-1:0]   id;
		logic [SLOT_W-1:0] slot;
		logic [CODE_W-1:0] status;
	} op_result_t;

	localparam int IDLE_LIMIT = 2000;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [FUNC_W-1:0]        func;
	logic [ID_W-1:0]          target_id;
	logic [CHAN_W-1:0]        channel;
	logic signed [CODE_W-1:0] exit_code;
	logic                     done;
	logic [OC_W-1:0]          outcome;
	logic [ID_W-1:0]          result_id;
	logic [SLOT_W-1:0]        result_slot;
	logic signed [CODE_W-1:0] reaped_status;

	process_table_lifecycle_scheduler u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .target_id(target_id), .channel(channel), .exit_code(exit_code),
		.done(done), .outcome(outcome), .result_id(result_id),
		.result_slot(result_slot), .reaped_status(reaped_status)
	);

	// shadow process table
	logic [ST_W-1:0]    tbl_state [SLOTS];
	logic [ID_W-1:0]    tbl_id    [SLOTS];
	logic [PTR_W-1:0]   tbl_parent[SLOTS];
	logic [SCHAN_W-1:0] tbl_chan  [SLOTS];
	logic               tbl_killed[SLOTS];
	logic [CODE_W-1:0]  tbl_code  [SLOTS];
	logic [ID_W-1:0]    next_pid;
	logic [PTR_W-1:0]   running_slot;
	logic [PTR_W-1:0]   init_idx;
	logic [SLOT_W-1:0]  rr_ptr;

	op_result_t pending_results[$];
	int         fail_count;
	int         idle_cycles;
	int         burst_left;

	// clock
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic void clear_slot(int s);
		tbl_state[s]  = ST_UNUSED;
		tbl_id[s]     = '0;
		tbl_parent[s] = NO_SLOT;
		tbl_chan[s]   = '0;
		tbl_killed[s] = 1'b0;
		tbl_code[s]   = '0;
	endfunction

	function automatic void wake_sleepers(logic [SCHAN_W-1:0] ch);
		for (int i = 0; i < SLOTS; i++)
			if (tbl_state[i] == ST_SLEEPING && tbl_chan[i] == ch)
				tbl_state[i] = ST_RUNNABLE;
	endfunction

	function automatic logic [SCHAN_W-1:0] child_wait_chan(logic [PTR_W-1:0] s);
		return {1'b1, 9'd0, s[SLOT_W-1:0]};
	endfunction

	// apply one operation to the shadow table and return its result word
	function automatic op_result_t table_apply(logic [FUNC_W-1:0] f, logic [ID_W-1:0] tid,
			logic [CHAN_W-1:0] ch, logic [CODE_W-1:0] code);
		op_result_t       r;
		logic [PTR_W-1:0] cur;
		int               s;
		bit               kids;
		bit               hit;
		r   = '{OC_OK, '0, '0, '0};
		cur = running_slot;
		if (f != F_CREATE && f != F_SCHED && f != F_WAKE && f != F_KILL && cur == NO_SLOT) begin
			r.oc = OC_NO_CUR;
			return r;
		end
		case (f)
			F_CREATE: begin
				if (init_idx != NO_SLOT && cur == NO_SLOT) begin
					r.oc = OC_NO_CUR;
					return r;
				end
				s = 0;
				while (s < SLOTS && tbl_state[s] != ST_UNUSED)
					s++;
				if (s == SLOTS) begin
					r.oc = OC_FULL;
					return r;
				end
				tbl_id[s]     = next_pid;
				next_pid      = (next_pid == ID_MAX) ? ID_W'(1) : next_pid + 1'b1;
				tbl_chan[s]   = '0;
				tbl_killed[s] = 1'b0;
				tbl_code[s]   = '0;
				tbl_state[s]  = ST_RUNNABLE;
				if (init_idx == NO_SLOT) begin
					init_idx      = PTR_W'(s);
					tbl_parent[s] = NO_SLOT;
				end else begin
					tbl_parent[s] = cur;
				end
				r.id   = tbl_id[s];
				r.slot = SLOT_W'(s);
			end
			F_SCHED: begin
				if (cur != NO_SLOT) begin
					r.id   = tbl_id[cur];
					r.slot = cur[SLOT_W-1:0];
					return r;
				end
				r.oc = OC_NONE_RN;
				for (int i = 0; i < SLOTS; i++) begin
					s = (rr_ptr + i) % SLOTS;
					if (tbl_state[s] == ST_RUNNABLE) begin
						tbl_state[s] = ST_RUNNING;
						running_slot = PTR_W'(s);
						rr_ptr       = SLOT_W'(s + 1);
						r            = '{OC_OK, tbl_id[s], SLOT_W'(s), '0};
						return r;
					end
				end
			end
			F_YIELD: begin
				tbl_state[cur] = ST_RUNNABLE;
				running_slot   = NO_SLOT;
			end
			F_SLEEP: begin
				tbl_chan[cur]  = {1'b0, ch};
				tbl_state[cur] = ST_SLEEPING;
				running_slot   = NO_SLOT;
			end
			F_WAKE: wake_sleepers({1'b0, ch});
			F_KILL: begin
				r.oc = OC_NO_ID;
				for (s = 0; s < SLOTS; s++)
					if (tbl_state[s] != ST_UNUSED && tbl_id[s] == tid) begin
						tbl_killed[s] = 1'b1;
						if (tbl_state[s] == ST_SLEEPING)
							tbl_state[s] = ST_RUNNABLE;
						r.oc = OC_OK;
						return r;
					end
			end
			F_EXIT: begin
				if (cur == init_idx) begin
					r.oc = OC_INIT_EX;
					return r;
				end
				// hand children to init
				for (int i = 0; i < SLOTS; i++)
					if (tbl_parent[i] == cur) begin
						tbl_parent[i] = init_idx;
						if (init_idx != NO_SLOT)
							wake_sleepers(child_wait_chan(init_idx));
					end
				if (tbl_parent[cur] != NO_SLOT)
					wake_sleepers(child_wait_chan(tbl_parent[cur]));
				tbl_code[cur]  = code;
				tbl_state[cur] = ST_ZOMBIE;
				running_slot   = NO_SLOT;
			end
			default: begin
				kids = 0;
				hit  = 0;
				for (s = 0; s < SLOTS && !hit; s++)
					if (tbl_parent[s] == cur && tbl_state[s] != ST_UNUSED) begin
						kids = 1;
						if (tbl_state[s] == ST_ZOMBIE) begin
							r   = '{OC_OK, tbl_id[s], SLOT_W'(s), tbl_code[s]};
							hit = 1;
							clear_slot(s);
						end
					end
				if (hit)
					return r;
				if (!kids || tbl_killed[cur]) begin
					r.oc = OC_NO_KIDS;
					return r;
				end
				tbl_chan[cur]  = child_wait_chan(cur);
				tbl_state[cur] = ST_SLEEPING;
				running_slot   = NO_SLOT;
				r.oc           = OC_BLOCKED;
			end
		endcase
		return r;
	endfunction

	// send one word, hold until accepted, then record its expected result
	task automatic send_word(logic [FUNC_W-1:0] f, logic [ID_W-1:0] tid,
			logic [CHAN_W-1:0] ch, logic [CODE_W-1:0] code);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
		end
		start     <= 1'b1;
		func      <= f;
		target_id <= tid;
		channel   <= ch;
		exit_code <= code;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_results.push_back(table_apply(f, tid, ch, code));
		burst_left--;
	endtask

	task automatic drop_start();
		start <= 1'b0;
		burst_left = 0;
	endtask

	// pick a target id: mostly the id held in a random slot, sometimes anything
	function automatic logic [ID_W-1:0] pick_target();
		int k;
		k = $urandom_range(0, 9);
		if (k < 7)
			return tbl_id[$urandom_range(0, SLOTS - 1)];
		else if (k < 9)
			return ID_W'($urandom());
		return (k[0]) ? ID_MAX : '0;
	endfunction

	function automatic logic [CHAN_W-1:0] pick_channel();
		if ($urandom_range(0, 3) != 0)
			return CHAN_W'($urandom_range(0, 3));
		return CHAN_W'($urandom());
	endfunction

	task automatic test_no_process();
		send_word(F_SCHED, '0, '0, '0);
		send_word(F_YIELD, '0, '0, '0);
		send_word(F_SLEEP, '0, '1, '0);
		send_word(F_EXIT, '0, '0, 32'h8000_0000);
		send_word(F_WAIT, '0, '0, '0);
		send_word(F_WAKE, '0, '1, '0);
		send_word(F_KILL, '0, '0, '0);
		send_word(F_KILL, ID_MAX, '0, '0);
	endtask

	task automatic test_init_rules();
		send_word(F_CREATE, '0, '0, '0);
		send_word(F_CREATE, '0, '0, '0);
		send_word(F_SCHED, '0, '0, '0);
		send_word(F_SCHED, '0, '0, '0);
		send_word(F_EXIT, '0, '0, 32'h7FFF_FFFF);
		send_word(F_WAIT, '0, '0, '0);
		send_word(F_CREATE, '0, '0, '0);
		send_word(F_YIELD, '0, '0, '0);
		send_word(F_SCHED, '0, '0, '0);
		send_word(F_SLEEP, '0, 15'h7FFF, '0);
		send_word(F_SCHED, '0, '0, '0);
		send_word(F_WAKE, '0, 15'h7FFF, '0);
		send_word(F_WAIT, '0, '0, '0);
		send_word(F_SCHED, '0, '0, '0);
		send_word(F_EXIT, '0, '0, 32'h8000_0000);
		send_word(F_SCHED, '0, '0, '0);
		send_word(F_WAIT, '0, '0, '0);
		send_word(F_KILL, ID_W'(1), '0, '0);
		send_word(F_WAIT, '0, '0, '0);
	endtask

	task automatic test_full_table();
		for (int n = 0; n < SLOTS + 4; n++) begin
			if (running_slot == NO_SLOT)
				send_word(F_SCHED, '0, '0, '0);
			send_word(F_CREATE, '0, '0, '0);
		end
	endtask

	// alternate fill-heavy and drain-heavy stretches of random operations
	task automatic test_lifecycle(int count);
		int               r;
		logic [FUNC_W-1:0] f;
		bit               fill;
		for (int n = 0; n < count; n++) begin
			fill = ((n / 150) % 2) == 1;
			r    = $urandom_range(0, 99);
			if (running_slot == NO_SLOT && r < 50)
				f = F_SCHED;
			else if (r < (fill ? 35 : 8))
				f = F_CREATE;
			else if (r < (fill ? 50 : 30))
				f = F_SCHED;
			else if (r < (fill ? 58 : 37))
				f = F_YIELD;
			else if (r < (fill ? 64 : 44))
				f = F_SLEEP;
			else if (r < (fill ? 70 : 52))
				f = F_WAKE;
			else if (r < (fill ? 77 : 62))
				f = F_KILL;
			else if (r < (fill ? 88 : 82))
				f = F_EXIT;
			else
				f = F_WAIT;
			send_word(f, pick_target(), pick_channel(), CODE_W'($urandom()));
		end
	endtask

	// check each result word against the oldest expectation
	always @(posedge clk) begin
		op_result_t e;
		if (done) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result word: outcome %0d", outcome);
				fail_count++;
			end else begin
				e = pending_results.pop_front();
				if (outcome !== e.oc) begin
					$error("outcome: expected %0d, actual %0d", e.oc, outcome);
					fail_count++;
				end
				if (result_id !== e.id) begin
					$error("result_id: expected %0d, actual %0d", e.id, result_id);
					fail_count++;
				end
				if (result_slot !== e.slot) begin
					$error("result_slot: expected %0d, actual %0d", e.slot, result_slot);
					fail_count++;
				end
				if (reaped_status !== e.status) begin
					$error("reaped_status: expected %0d, actual %0d",
						$signed(e.status), reaped_status);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake of either kind
	always @(posedge clk) begin
		if (done || (start && !busy))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		func        = F_CREATE;
		target_id   = '0;
		channel     = '0;
		exit_code   = '0;
		fail_count  = 0;
		idle_cycles = 0;
		burst_left  = 0;
		for (int i = 0; i < SLOTS; i++)
			clear_slot(i);
		next_pid     = ID_W'(1);
		running_slot = NO_SLOT;
		init_idx     = NO_SLOT;
		rr_ptr       = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_no_process();
		test_init_rules();
		test_full_table();
		test_lifecycle(1350);
		drop_start();

		// drain outstanding results
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* process_table_lifecycle_scheduler.f */
design/ptls_pkg.sv
design/ptls_ram.sv
design/ptls_dp.sv
design/ptls_ctrl.sv
design/process_table_lifecycle_scheduler.sv
sim/tb_process_table_lifecycle_scheduler.sv
